[rtl/core/btc_pkg.sv]
// Shared types and constants for the backlight timeout controller.
package btc_pkg;

  localparam int unsigned TimeoutWidth = 16;
  localparam int unsigned LevelWidth   = 7;
  localparam int unsigned KeyWidth     = 32;
  localparam int unsigned DurWidth     = 16;
  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 16;

  localparam logic [TimeoutWidth-1:0] ResetTimeout = TimeoutWidth'(50);
  localparam logic [LevelWidth-1:0]   ResetLevel   = LevelWidth'(50);
  localparam logic [LevelWidth-1:0]   MaxLevel     = LevelWidth'(100);

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_TIMEOUT = 2'd0,
    CFG_LEVEL   = 2'd1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    REQ_TICK    = 3'd0,
    REQ_TAP     = 3'd1,
    REQ_RELEASE = 3'd2,
    REQ_BUTTON  = 3'd3,
    REQ_POKE    = 3'd4,
    REQ_LOCK    = 3'd5,
    REQ_UNLOCK  = 3'd6
  } req_type_t;

  typedef struct packed {
    logic [2:0]          req;
    logic [DurWidth-1:0] dur;
    logic [KeyWidth-1:0] key;
  } item_t;

  typedef struct packed {
    logic                  light_on;
    logic [LevelWidth-1:0] pwm_duty;
    logic                  is_locked;
    logic [KeyWidth-1:0]   granted_key;
    logic                  timed_out;
  } result_t;

  typedef struct packed {
    logic [TimeoutWidth-1:0] default_timeout;
    logic [LevelWidth-1:0]   bright_level;
  } cfg_t;

endpackage

[rtl/core/backlight_timeout_controller_top.sv]
// Top level of the backlight timeout controller.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------------
//   in      | to block  | in_valid / in_ready    | req_type, poke_duration, unlock_key
//   out     | from block| out_valid / out_ready  | light_on, pwm_duty, is_locked,
//           |           |                        | granted_key, timed_out
//   cfg     | to block  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Each event transaction lands in an input register, is evaluated against the
// light/lock/tick state, and its result is written to the output register.
// Throughput is one transaction per cycle while the output is not stalled;
// out_valid rises when an item moves from the input register into the result
// register. The add and compare on the tick counter set the critical path.
// rst (synchronous) clears state to off, unlocked, serial 0, counter 0,
// deadline 0, and config to timeout 50, level 50. A stalled output holds its
// result and backs up into the input register; cfg_ready is always high.
module backlight_timeout_controller_top
  import btc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  // event input
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [2:0]              req_type,
  input  logic [DurWidth-1:0]     poke_duration,
  input  logic [KeyWidth-1:0]     unlock_key,
  // result output
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    light_on,
  output logic [LevelWidth-1:0]   pwm_duty,
  output logic                    is_locked,
  output logic [KeyWidth-1:0]     granted_key,
  output logic                    timed_out,
  // configuration writes
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CfgIdxWidth-1:0]  cfg_index,
  input  logic [CfgDataWidth-1:0] cfg_data
);

  cfg_t    cfg;
  item_t   item_q;
  logic    item_vld;
  logic    advance;
  result_t res;
  result_t res_q;

  // item moves to the result register when that register is free or draining
  assign advance  = item_vld && (!out_valid || out_ready);
  assign in_ready = !item_vld || advance;

  btc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  btc_engine #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_engine (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .item (item_q),
    .cfg  (cfg),
    .res  (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld <= 1'b0;
    end else if (in_ready) begin
      item_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_q.req <= req_type;
      item_q.dur <= poke_duration;
      item_q.key <= unlock_key;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign light_on    = res_q.light_on;
  assign pwm_duty    = res_q.pwm_duty;
  assign is_locked   = res_q.is_locked;
  assign granted_key = res_q.granted_key;
  assign timed_out   = res_q.timed_out;

  // a timeout always leaves the light off
  a_timeout_off : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(timed_out && light_on))
    else $error("timed_out with light_on");

  // a held lock keeps the light on
  a_lock_on : assert property (@(posedge clk) disable iff (rst)
    out_valid && is_locked |-> light_on)
    else $error("locked while light off");

  // a nonzero key is only handed out with the lock held
  a_key_locked : assert property (@(posedge clk) disable iff (rst)
    out_valid && granted_key != '0 |-> is_locked)
    else $error("key granted without lock");

  // an item blocked by a stalled result stays in the input register
  a_item_held : assert property (@(posedge clk) disable iff (rst)
    item_vld && !advance |=> item_vld && $stable(item_q))
    else $error("pending item lost");

endmodule

[rtl/core/btc_cfg.sv]
// Configuration registers: default timeout and brightness level.
module btc_cfg
  import btc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CfgIdxWidth-1:0]  cfg_index,
  input  logic [CfgDataWidth-1:0] cfg_data,
  output cfg_t                    cfg
);

  logic [TimeoutWidth-1:0] default_timeout;
  logic [LevelWidth-1:0]   bright_level;
  logic [LevelWidth-1:0]   level_in;

  assign cfg_ready = 1'b1;
  assign level_in  = cfg_data[LevelWidth-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      default_timeout <= ResetTimeout;
      bright_level    <= ResetLevel;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_TIMEOUT) begin
        default_timeout <= cfg_data[TimeoutWidth-1:0];
      end
      // levels above full scale are dropped
      if (cfg_index == CFG_LEVEL && level_in <= MaxLevel) begin
        bright_level <= level_in;
      end
    end
  end

  assign cfg.default_timeout = default_timeout;
  assign cfg.bright_level    = bright_level;

endmodule

[rtl/core/btc_engine.sv]
// Light, lock and tick state with the per-event update logic.
module btc_engine
  import btc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  logic                   lamp_on, lamp_on_next;
  logic                   lock_held, lock_held_next;
  logic [KeyWidth-1:0]    lock_serial, lock_serial_next;
  logic [COUNT_WIDTH-1:0] tick_count, tick_count_next;
  logic [COUNT_WIDTH-1:0] deadline, deadline_next;

  logic [COUNT_WIDTH-1:0] base_count;
  logic [COUNT_WIDTH-1:0] tick_inc;
  logic [COUNT_WIDTH-1:0] tmo_ext;
  logic [COUNT_WIDTH-1:0] dur_ext;
  logic [KeyWidth-1:0]    serial_inc;
  logic [KeyWidth-1:0]    granted;
  logic                   expired;

  // turning on from off restarts the count
  assign base_count = lamp_on ? tick_count : '0;
  assign tick_inc   = tick_count + COUNT_WIDTH'(1);
  assign tmo_ext    = COUNT_WIDTH'(cfg.default_timeout);
  assign dur_ext    = COUNT_WIDTH'(item.dur);
  assign serial_inc = lock_serial + KeyWidth'(1);

  always_comb begin
    lamp_on_next     = lamp_on;
    lock_held_next   = lock_held;
    lock_serial_next = lock_serial;
    tick_count_next  = tick_count;
    deadline_next    = deadline;
    granted          = '0;
    expired          = 1'b0;
    unique case (item.req)
      REQ_TICK: begin
        if (lamp_on) begin
          tick_count_next = tick_inc;
          if (!lock_held && tick_inc > deadline) begin
            lamp_on_next = 1'b0;
            expired      = 1'b1;
          end
        end
      end
      REQ_TAP: begin
        lamp_on_next    = 1'b1;
        tick_count_next = base_count;
        deadline_next   = base_count + tmo_ext;
      end
      REQ_BUTTON: begin
        if (!lock_held) begin
          if (lamp_on) begin
            lamp_on_next = 1'b0;
          end else begin
            lamp_on_next    = 1'b1;
            tick_count_next = base_count;
            deadline_next   = base_count + tmo_ext;
          end
        end
      end
      REQ_POKE: begin
        lamp_on_next    = 1'b1;
        tick_count_next = base_count;
        deadline_next   = base_count + dur_ext;
      end
      REQ_LOCK: begin
        if (!lock_held) begin
          lock_held_next   = 1'b1;
          lamp_on_next     = 1'b1;
          tick_count_next  = base_count;
          lock_serial_next = serial_inc;
          granted          = serial_inc;
        end
      end
      REQ_UNLOCK: begin
        if (lock_held && lock_serial == item.key) begin
          lock_held_next  = 1'b0;
          lamp_on_next    = 1'b1;
          tick_count_next = base_count;
          deadline_next   = base_count + tmo_ext;
        end
      end
      default: begin
        // release and the unused code do nothing
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lamp_on     <= 1'b0;
      lock_held   <= 1'b0;
      lock_serial <= '0;
      tick_count  <= '0;
      deadline    <= '0;
    end else if (fire) begin
      lamp_on     <= lamp_on_next;
      lock_held   <= lock_held_next;
      lock_serial <= lock_serial_next;
      tick_count  <= tick_count_next;
      deadline    <= deadline_next;
    end
  end

  assign res.light_on    = lamp_on_next;
  assign res.pwm_duty    = lamp_on_next ? cfg.bright_level : '0;
  assign res.is_locked   = lock_held_next;
  assign res.granted_key = granted;
  assign res.timed_out   = expired;

endmodule
